// ----- rtl/csf_pkg.sv -----
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, constants and the tap weight table of the column smoother.
// ----------------------------------------------------------------------------
package csf_pkg;

   localparam int MAX_HEIGHT  = 64;
   localparam int ADDR_W      = $clog2(MAX_HEIGHT);
   localparam int CNT_W       = $clog2(MAX_HEIGHT + 1);
   localparam int PIX_W       = 8;
   localparam int PASS_W      = 8;
   localparam int TAPS        = 5;
   localparam int TAP_W       = $clog2(TAPS);
   localparam int TAP_SUM     = 1 + 2 + 4 + 2 + 1;
   // widest weighted sum is 255 * TAP_SUM
   localparam int SUM_W       = $clog2(((1 << PIX_W) - 1) * TAP_SUM + 1);
   // x / 10 == (x * 52429) >> 19 for every x below 2^16
   localparam int DIV_MUL_W   = 16;
   localparam logic [DIV_MUL_W-1:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W      = SUM_W + DIV_MUL_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EDGES = 8'd1;
   localparam logic [PASS_W-1:0]    PASS_COUNT_RESET = 8'd5;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
      logic             keep;
   } csf_item_type;

   typedef struct packed {
      logic [PASS_W-1:0] pass_count;
      logic              wrap_edges;
   } csf_cfg_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FILTER,
      ST_DRAIN,
      ST_EMIT
   } csf_state_type;

   function automatic logic [2:0] tap_weight(input logic [TAP_W-1:0] tap);
      logic [2:0] w;
      unique case (tap)
         3'd0:    w = 3'd1;
         3'd1:    w = 3'd2;
         3'd2:    w = 3'd4;
         3'd3:    w = 3'd2;
         3'd4:    w = 3'd1;
         default: w = 3'd0;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/column_smoothing_filter_unit.sv -----
// ----------------------------------------------------------------------------
// column_smoothing_filter_unit
// Five-tap 1,2,4,2,1 column smoother with a request queue in front of a
// single-read filter engine.
// ----------------------------------------------------------------------------
// Loading stores each kept pixel as the engine pops it; the queue registers a pixel before it is stored.
// Each pass over a column of height h makes one tap read per cycle from a bank.
// Results leave from ST_EMIT through rd_data_ff, one per cycle, after the last pass or after loading
// when no pass runs; a column is loaded, smoothed over pass_count passes, then emitted.
// Synchronous reset empties the queue and restores pass_count 5 and clamped edges.
// Results cannot be stalled: each is shown for one cycle with rsp_valid.
module column_smoothing_filter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [csf_pkg::PIX_W-1:0]      req_pixel_in,
   input  logic                           req_column_end,
   output logic                           rsp_valid,
   output logic [csf_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                           rsp_last_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [csf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csf_pkg::CSR_DATA_W-1:0] csr_data
);
   import csf_pkg::*;

   csf_cfg_type  cfg;
   csf_item_type item;
   logic         item_valid;
   logic         item_pop;

   csf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   csf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_in   (req_pixel_in),
      .req_column_end (req_column_end),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   csf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_last_out  (rsp_last_out)
   );

endmodule

// ----- rtl/csf_csr.sv -----
// ----------------------------------------------------------------------------
// csf_csr
// Configuration registers: pass count and edge mode.
// ----------------------------------------------------------------------------
module csf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [csf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csf_pkg::CSR_DATA_W-1:0] csr_data,
   output csf_pkg::csf_cfg_type           cfg
);
   import csf_pkg::*;

   csf_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pass_count <= PASS_COUNT_RESET;
         cfg_ff.wrap_edges <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_PASS_COUNT) begin
            cfg_ff.pass_count <= csr_data[PASS_W-1:0];
         end else if (csr_index == CSR_WRAP_EDGES) begin
            cfg_ff.wrap_edges <= csr_data[0];
         end
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/csf_front.sv -----
// ----------------------------------------------------------------------------
// csf_front
// Accepts requests, marks pixels beyond the column store as dropped and
// queues them for the filter engine.
// ----------------------------------------------------------------------------
module csf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [csf_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                        req_column_end,
   output logic                        item_valid,
   output csf_pkg::csf_item_type       item,
   input  logic                        item_pop
);
   import csf_pkg::*;

   csf_item_type      queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;
   logic [CNT_W-1:0]  seen_ff;
   logic              push;
   logic              pop;
   logic              keep;

   assign busy = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = item_pop && (fill_ff != '0);
   assign keep = (seen_ff < CNT_W'(MAX_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         seen_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
            if (req_column_end) begin
               seen_ff <= '0;
            end else if (keep) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].pixel <= req_pixel_in;
         queue_ff[wr_ptr_ff].last  <= req_column_end;
         queue_ff[wr_ptr_ff].keep  <= keep;
      end
   end

   assign item_valid = (fill_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

endmodule

// ----- rtl/csf_back.sv -----
// ----------------------------------------------------------------------------
// csf_back
// Filter engine: loads the column, runs the smoothing passes between two
// ping-pong banks with one tap read per cycle, then streams the column out.
// ----------------------------------------------------------------------------
module csf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  csf_pkg::csf_cfg_type        cfg,
   input  logic                        item_valid,
   input  csf_pkg::csf_item_type       item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   output logic [csf_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                        rsp_last_out
);
   import csf_pkg::*;

   localparam int KW = CNT_W + 2;

   logic [PIX_W-1:0] bank0 [MAX_HEIGHT];
   logic [PIX_W-1:0] bank1 [MAX_HEIGHT];

   csf_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic [CNT_W-1:0]  h_ff, h_in;
   logic [ADDR_W-1:0] y_ff, y_in;
   logic [TAP_W-1:0]  t_ff, t_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              src_ff, src_in;

   logic              load_we;
   logic              issue_tap;
   logic              issue_emit;
   logic              emit_last;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] tap_addr;
   logic [CNT_W-1:0]  h_new;
   logic              y_at_end;

   logic [PIX_W-1:0]  rd_data_ff;
   logic              tap_valid_ff;
   logic [TAP_W-1:0]  tap_ff;
   logic [ADDR_W-1:0] tap_y_ff;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              sum_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [ADDR_W-1:0] sum_y_ff;
   logic [PROD_W-1:0] prod;
   logic [PIX_W-1:0]  quotient;
   logic              emit_valid_ff;
   logic              emit_last_ff;

   logic [KW-1:0]     k_raw;
   logic [KW-1:0]     k_fix;
   logic [KW-1:0]     h_w;

   assign y_at_end = (CNT_W'(y_ff) == h_ff - 1'b1);

   // neighbour index with wrap or clamp at the column ends
   always_comb begin
      h_w   = KW'(h_ff);
      k_raw = KW'(y_ff) + KW'(t_ff) - KW'(2);
      if (k_raw[KW-1]) begin
         k_fix = cfg.wrap_edges ? (k_raw + h_w) : '0;
      end else if (k_raw >= h_w) begin
         k_fix = cfg.wrap_edges ? (k_raw - h_w) : (h_w - 1'b1);
      end else begin
         k_fix = k_raw;
      end
      tap_addr = k_fix[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         h_ff          <= '0;
         y_ff          <= '0;
         t_ff          <= '0;
         pass_ff       <= '0;
         src_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         h_ff          <= h_in;
         y_ff          <= y_in;
         t_ff          <= t_in;
         pass_ff       <= pass_in;
         src_ff        <= src_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      h_in          = h_ff;
      y_in          = y_ff;
      t_in          = t_ff;
      pass_in       = pass_ff;
      src_in        = src_ff;
      item_pop      = 1'b0;
      load_we       = 1'b0;
      issue_tap     = 1'b0;
      issue_emit    = 1'b0;
      emit_last     = 1'b0;
      rd_addr       = y_ff;
      h_new         = item.keep ? (load_count_ff + 1'b1) : load_count_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.keep) begin
                  load_we       = 1'b1;
                  load_count_in = load_count_ff + 1'b1;
               end
               if (item.last) begin
                  h_in    = h_new;
                  y_in    = '0;
                  t_in    = '0;
                  pass_in = '0;
                  src_in  = 1'b0;
                  if ((h_new > CNT_W'(1)) && (cfg.pass_count != '0)) begin
                     state_in = ST_FILTER;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_FILTER: begin
            issue_tap = 1'b1;
            rd_addr   = tap_addr;
            if (t_ff == TAP_W'(TAPS - 1)) begin
               t_in = '0;
               if (y_at_end) begin
                  state_in = ST_DRAIN;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last write of the pass must land before the next pass reads
            if (!tap_valid_ff && !sum_valid_ff) begin
               pass_in = pass_ff + 1'b1;
               src_in  = !src_ff;
               y_in    = '0;
               t_in    = '0;
               if ((pass_ff + 1'b1) == cfg.pass_count) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FILTER;
               end
            end
         end
         ST_EMIT: begin
            issue_emit = 1'b1;
            emit_last  = y_at_end;
            if (y_at_end) begin
               load_count_in = '0;
               state_in      = ST_LOAD;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // accumulate one weighted tap per cycle
   always_comb begin
      acc_in = ((tap_ff == '0) ? '0 : acc_ff)
             + SUM_W'(rd_data_ff) * SUM_W'(tap_weight(tap_ff));
   end

   assign prod     = PROD_W'(sum_ff) * PROD_W'(DIV10_MUL);
   assign quotient = prod[DIV10_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         emit_valid_ff <= 1'b0;
         emit_last_ff  <= 1'b0;
      end else begin
         tap_valid_ff  <= issue_tap;
         sum_valid_ff  <= tap_valid_ff && (tap_ff == TAP_W'(TAPS - 1));
         emit_valid_ff <= issue_emit;
         emit_last_ff  <= issue_emit && emit_last;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff   <= t_ff;
      tap_y_ff <= y_ff;
      if (tap_valid_ff) begin
         acc_ff   <= acc_in;
         sum_ff   <= acc_in;
         sum_y_ff <= tap_y_ff;
      end
   end

   // ping-pong banks: passes read bank src and write the other one
   always_ff @(posedge clock) begin
      if (load_we) begin
         bank0[load_count_ff[ADDR_W-1:0]] <= item.pixel;
      end else if (sum_valid_ff && src_ff) begin
         bank0[sum_y_ff] <= quotient;
      end
      if (sum_valid_ff && !src_ff) begin
         bank1[sum_y_ff] <= quotient;
      end
      if (issue_tap || issue_emit) begin
         rd_data_ff <= src_ff ? bank1[rd_addr] : bank0[rd_addr];
      end
   end

   assign rsp_valid     = emit_valid_ff;
   assign rsp_pixel_out = rd_data_ff;
   assign rsp_last_out  = emit_last_ff;

endmodule

// ----- rtl/csf_checker.sv -----
// ----------------------------------------------------------------------------
// csf_checker
// Port-level checks on the column smoother, bound to the top level.
// ----------------------------------------------------------------------------
module csf_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_out
);

   // queue is empty right after reset
   assert property (@(posedge clock) reset |=> !busy)
      else $error("busy high after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // a column streams out without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_out) |=> rsp_valid)
      else $error("gap inside column output");

   // a new column needs loading before it can be emitted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |=> !rsp_valid)
      else $error("result straight after column end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |-> rsp_valid)
      else $error("last marker without result");

endmodule

bind column_smoothing_filter_unit csf_checker u_csf_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_last_out (rsp_last_out)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the column smoother. Columns of pixels are sent
// with random gaps, a local predictor applies the 1,2,4,2,1 passes under the
// current pass count and edge mode, and every result pixel is compared
// with the oldest predicted pixel. Directed columns cover extremes, height
// one, zero and maximum passes, wrapped and clamped edges, unmapped
// register indexes and a column beyond the maximum height. Random phases
// then vary the settings and column heights.
// ----------------------------------------------------------------------------
module tb_top;
   import csf_pkg::*;

   localparam int IDLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } smoothed_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PIX_W-1:0]      req_pixel_in;
   logic                  req_column_end;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_last_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state
   logic [PIX_W-1:0]   column_copy [MAX_HEIGHT];
   int unsigned        pixels_held = 0;
   logic [PASS_W-1:0]  passes_cfg  = PASS_COUNT_RESET;
   logic               wrap_cfg    = 1'b0;
   smoothed_pixel_type smoothed_q [$];

   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   bit          no_idle     = 1'b0;

   column_smoothing_filter_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_in   (req_pixel_in),
      .req_column_end (req_column_end),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_out   (rsp_last_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int tap_index(input int y, input int d, input int h, input logic wrap);
      int k;
      k = y + d;
      if (k < 0) begin
         k = wrap ? k + h : 0;
      end else if (k >= h) begin
         k = wrap ? k - h : h - 1;
      end
      if (k < 0) k = 0;
      if (k >= h) k = h - 1;
      return k;
   endfunction

   // store one pixel; on the column end run all passes and queue the column
   task automatic smooth_and_queue(input logic [PIX_W-1:0] pix, input logic col_end);
      logic [PIX_W-1:0]   next_col [MAX_HEIGHT];
      int                 h;
      int unsigned        acc;
      smoothed_pixel_type sp;
      if (pixels_held < MAX_HEIGHT) begin
         column_copy[pixels_held] = pix;
         pixels_held++;
      end
      if (col_end) begin
         h = pixels_held;
         if (h > 1) begin
            for (int p = 0; p < passes_cfg; p++) begin
               for (int y = 0; y < h; y++) begin
                  acc = 32'(column_copy[tap_index(y, -2, h, wrap_cfg)])
                      + 2 * 32'(column_copy[tap_index(y, -1, h, wrap_cfg)])
                      + 4 * 32'(column_copy[y])
                      + 2 * 32'(column_copy[tap_index(y, 1, h, wrap_cfg)])
                      + 32'(column_copy[tap_index(y, 2, h, wrap_cfg)]);
                  next_col[y] = PIX_W'(acc / TAP_SUM);
               end
               for (int y = 0; y < h; y++) column_copy[y] = next_col[y];
            end
         end
         for (int y = 0; y < h; y++) begin
            sp.pixel = column_copy[y];
            sp.last  = (y == h - 1);
            smoothed_q.push_back(sp);
         end
         pixels_held = 0;
      end
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic col_end);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_pixel_in   <= pix;
      req_column_end <= col_end;
      do @(posedge clock); while (busy !== 1'b0);
      smooth_and_queue(pix, col_end);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // hold off until every predicted pixel has come out, then let the block settle
   task automatic wait_drained();
      pause_sender();
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_PASS_COUNT) begin
         passes_cfg = data;
      end else if (idx == CSR_WRAP_EDGES) begin
         wrap_cfg = data[0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [PASS_W-1:0] passes, input logic wrap);
      logic [CSR_DATA_W-1:0] wrap_word;
      wrap_word = {7'($urandom_range(0, 127)), wrap};
      wait_drained();
      write_csr(CSR_PASS_COUNT, passes);
      write_csr(CSR_WRAP_EDGES, wrap_word);
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   task automatic send_column(input int h);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < h; i++) send_pixel(random_pixel(), i == h - 1);
      no_idle = 1'b0;
   endtask

   task automatic test_reset_defaults();
      // five passes, clamped edges, straight out of reset
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b1);
   endtask

   task automatic test_zero_passes();
      configure(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b1);
   endtask

   task automatic test_wrap_edges();
      configure(8'd1, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd0, 1'b1);
   endtask

   task automatic test_max_passes();
      configure(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd77, 1'b1);
   endtask

   task automatic test_unmapped_index();
      // unknown indexes leave both registers alone; only bit 0 of wrap counts
      wait_drained();
      write_csr(8'hFF, 8'h00);
      write_csr(8'd2, 8'hFF);
      write_csr(CSR_WRAP_EDGES, 8'hFE);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd250, 1'b1);
   endtask

   task automatic test_tall_columns();
      // the store fills up and the end pixel itself is dropped
      configure(8'd2, 1'b1);
      send_column(MAX_HEIGHT + 1);
   endtask

   task automatic test_random_columns(input int n_items, input logic [PASS_W-1:0] passes,
                                      input logic wrap, input int max_h);
      int sent;
      int h;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      configure(passes, wrap);
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) h = $urandom_range(1, max_h);
         else h = $urandom_range(1, (max_h < 8) ? max_h : 8);
         send_column(h);
         sent += h;
         if (!paused && sent >= n_items / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_pixel_in   = '0;
      req_column_end = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_passes();
      test_wrap_edges();
      test_max_passes();
      test_unmapped_index();
      test_tall_columns();
      test_random_columns(10, 8'd1, 1'b0, 16);
      test_random_columns(10, 8'd2, 1'b1, 16);
      test_random_columns(8, 8'd0, 1'b1, 72);
      test_random_columns(6, 8'd255, 1'b1, 3);
      test_random_columns(10, PASS_W'($urandom_range(0, 12)), 1'($urandom_range(0, 1)), 40);
      test_random_columns(8, PASS_W'($urandom_range(3, 9)), 1'($urandom_range(0, 1)), 12);
      test_random_columns(6, 8'd255, 1'b0, 3);

      wait_drained();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // compare each result pixel with the oldest prediction
   always @(posedge clock) begin
      smoothed_pixel_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (smoothed_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected pixel: expected none, actual pixel %0d last %b",
                     $time, rsp_pixel_out, rsp_last_out);
         end else begin
            want = smoothed_q.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               error_count++;
               $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                        $time, want.pixel, rsp_pixel_out);
            end
            if (rsp_last_out !== want.last) begin
               error_count++;
               $display("%0t: last_out mismatch: expected %b, actual %b",
                        $time, want.last, rsp_last_out);
            end
         end
      end
   end

   // watchdog on cycles with no request, result or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
